>>> rtl/wma_pkg.sv
package wma_pkg;

  localparam int SampleWidth   = 32;
  localparam int CfgWidth      = 7;
  localparam int MaxWindowDef  = 100;

  localparam logic [CfgWidth-1:0] WindowReset = CfgWidth'(100);

endpackage

>>> rtl/wma_div.sv
module wma_div
  import wma_pkg::*;
#(
  parameter int DvdWidth = SampleWidth,
  parameter int DvsWidth = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DvdWidth-1:0] dividend_i,
  input  logic [DvsWidth-1:0] divisor_i,
  output logic                done_o,
  output logic [DvdWidth-1:0] quotient_o,
  output logic [DvsWidth-1:0] remainder_o
);

  localparam int CntWidth = $clog2(DvdWidth + 1);

  logic [DvdWidth-1:0] dvd_q, dvd_d;
  logic [DvsWidth-1:0] dvs_q;
  logic [DvsWidth-1:0] rem_q, rem_d;
  logic [CntWidth-1:0] cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [DvsWidth:0]   trial;
  logic                fits;

  always_comb begin
    trial = {rem_q, dvd_q[DvdWidth-1]};
    fits  = (trial >= {1'b0, dvs_q});
    if (fits) begin
      rem_d = DvsWidth'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = DvsWidth'(trial);
    end
    dvd_d = {dvd_q[DvdWidth-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntWidth'(DvdWidth);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntWidth'(1);
      if (cnt_q == CntWidth'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

>>> rtl/windowed_moving_average_unit.sv
// Simple moving average over the last window_size samples.
//
// Input stream (s_axis_*): one unsigned 32-bit sample per transaction.
// Output stream (m_axis_*): one 32-bit floor mean per accepted sample, in order.
// Configuration: cfg_we_i writes cfg_wdata_i into the window register; the
// effective window is that value clamped to 1 .. MAX_WINDOW. Write it only
// while no sample is in flight.
//
// Each sample passes from acceptance to the output register in order: the
// FETCH, GROW and ADD states read and update the ring and the running sum
// through the ring memory's single read port, then the bit-serial divider
// runs (one quotient bit per cycle), then the output register is loaded. One
// sample is worked on at a time; s_axis_tready is high only while the
// datapath is empty, so a new sample waits until the last mean is loaded.
// A finished mean waits in the output register while the receiver stalls, and
// the next sample is accepted meanwhile; the divider result is held until the
// output register frees up.
// Reset clears the running sum, fill count and write position and sets the
// window to 100. The ring itself is not cleared.
module windowed_moving_average_unit
  import wma_pkg::*;
#(
  parameter int MAX_WINDOW = MaxWindowDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgWidth-1:0]    cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SampleWidth-1:0] s_axis_tdata,  // [31:0] sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [SampleWidth-1:0] m_axis_tdata   // [31:0] average
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FW = $clog2(MAX_WINDOW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_GROW,
    S_ADD,
    S_DIV
  } state_e;

  state_e                 state_q;
  logic [CfgWidth-1:0]    window_size_q;
  logic [AW-1:0]          wp_q;
  logic [FW-1:0]          fill_q;
  logic [FW-1:0]          oldfill_q;
  logic [FW-1:0]          win_q;
  logic [SampleWidth-1:0] sum_q;
  logic [SampleWidth-1:0] sample_q;
  logic                   hit_old_q;
  logic                   hit_new_q;
  logic                   add_grow_q;
  logic                   m_valid_q;
  logic [SampleWidth-1:0] m_data_q;

  logic [SampleWidth-1:0] ring_q [MAX_WINDOW];
  logic [SampleWidth-1:0] rdata_q;
  logic [AW-1:0]          mem_raddr;
  logic                   mem_we;

  logic [FW-1:0]          eff_w;
  logic                   grow;
  logic [FW-1:0]          newfill;
  logic [SampleWidth-1:0] sum_fin;
  logic                   accept;
  logic                   out_free;
  logic                   out_load;
  logic                   div_start;
  logic                   sum_done;
  logic                   mod_done;
  logic [SampleWidth-1:0] avg;
  logic [FW-1:0]          mod_rem;
  logic [AW:0]            wp_inc;
  logic [SampleWidth-1:0] sum_quo_unused_guard;

  always_comb begin
    if (32'(window_size_q) > 32'(MAX_WINDOW)) begin
      eff_w = FW'(MAX_WINDOW);
    end else if (window_size_q == '0) begin
      eff_w = FW'(1);
    end else begin
      eff_w = FW'(window_size_q);
    end
    grow    = (fill_q < eff_w);
    newfill = grow ? fill_q + FW'(1) : fill_q;
    sum_fin = sum_q + (hit_new_q ? sample_q : '0);
    wp_inc  = (AW + 1)'(wp_q) + (AW + 1)'(1);
  end

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign out_load  = (state_q == S_DIV) && sum_done && mod_done && out_free;
  assign div_start = (state_q == S_ADD);
  assign mem_we    = (state_q == S_GROW);
  assign mem_raddr = (state_q == S_IDLE) ? wp_q : oldfill_q[AW-1:0];

  assign sum_quo_unused_guard = avg;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[wp_q] <= sample_q;
    end
    rdata_q <= ring_q[mem_raddr];
  end

  wma_div #(
    .DvdWidth(SampleWidth),
    .DvsWidth(FW)
  ) u_sum_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_fin),
    .divisor_i  (fill_q),
    .done_o     (sum_done),
    .quotient_o (avg),
    .remainder_o()
  );

  wma_div #(
    .DvdWidth(AW + 1),
    .DvsWidth(FW)
  ) u_mod_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (wp_inc),
    .divisor_i  (win_q),
    .done_o     (mod_done),
    .quotient_o (),
    .remainder_o(mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WindowReset;
    end else if (cfg_we_i) begin
      window_size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wp_q      <= '0;
      fill_q    <= '0;
      sum_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            sample_q   <= s_axis_tdata;
            oldfill_q  <= fill_q;
            win_q      <= eff_w;
            fill_q     <= newfill;
            hit_old_q  <= (FW'(wp_q) < fill_q);
            hit_new_q  <= (FW'(wp_q) < newfill);
            add_grow_q <= grow && (FW'(wp_q) != fill_q);
            state_q    <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (hit_old_q) begin
            sum_q <= sum_q - rdata_q;
          end
          state_q <= S_GROW;
        end
        S_GROW: begin
          if (add_grow_q) begin
            sum_q <= sum_q + rdata_q;
          end
          state_q <= S_ADD;
        end
        S_ADD: begin
          sum_q   <= sum_fin;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (out_load) begin
            m_data_q  <= sum_quo_unused_guard;
            wp_q      <= mod_rem[AW-1:0];
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_done |-> mod_done)
    else $error("window position not ready with the mean");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |-> (fill_q == oldfill_q || fill_q == oldfill_q + FW'(1)))
    else $error("fill count moved by more than one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sum_done && mod_done && out_free)
      |=> (m_axis_tvalid && m_axis_tdata == $past(avg)))
    else $error("mean not loaded into output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("second sample accepted while busy");
`endif

endmodule

>>> sim/windowed_moving_average_unit_tb.sv
module windowed_moving_average_unit_tb
  import wma_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RingDepth    = MaxWindowDef;
  localparam int PhaseItems   = 155;
  localparam int SettleCycles = 50;

  typedef struct packed {
    logic [SampleWidth-1:0] sample;
    logic                   known;
    logic [SampleWidth-1:0] average;
  } probe_t;

  localparam int NumProbes = 16;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgWidth-1:0]    cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [SampleWidth-1:0] s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [SampleWidth-1:0] m_axis_tdata;

  logic [SampleWidth-1:0] pending_averages [$];
  int                     fail_count = 0;

  logic [CfgWidth-1:0]    window_reg;
  logic [SampleWidth-1:0] ring [RingDepth];
  int                     ring_pos;
  int                     held_count;

  int                     send_burst = 0;
  int                     recv_burst = 0;

  probe_t probes [NumProbes] = '{
    '{32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{32'hFFFF_FFFF, 1'b1, 32'h5555_5554},
    '{32'h0000_0001, 1'b1, 32'h3FFF_FFFF},
    '{32'h8000_0000, 1'b0, 32'h0},
    '{32'hAAAA_AAAA, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 1'b0, 32'h0},
    '{32'h0001_0000, 1'b0, 32'h0},
    '{32'hFFFF_0000, 1'b0, 32'h0},
    '{32'h0000_FFFF, 1'b0, 32'h0},
    '{32'h1234_5678, 1'b0, 32'h0},
    '{32'hFEDC_BA98, 1'b0, 32'h0},
    '{32'h0000_0002, 1'b0, 32'h0},
    '{32'h0000_0003, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b0, 32'h0}
  };

  logic [CfgWidth-1:0] phase_windows [9];

  windowed_moving_average_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [SampleWidth-1:0] next_average(input logic [SampleWidth-1:0] s);
    int                     span;
    logic [SampleWidth-1:0] total;
    span = (window_reg > RingDepth) ? RingDepth : int'(window_reg);
    if (span == 0) begin
      span = 1;
    end
    if (held_count < span) begin
      held_count++;
    end
    if (ring_pos < RingDepth) begin
      ring[ring_pos] = s;
    end
    ring_pos = (ring_pos + 1) % span;
    total = '0;
    for (int i = 0; i < held_count && i < RingDepth; i++) begin
      total += ring[i];
    end
    return (held_count != 0) ? total / SampleWidth'(held_count) : '0;
  endfunction

  function automatic int draw_gap(ref int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      burst = $urandom_range(10, 40);
    end
    return $urandom_range(0, 4);
  endfunction

  function automatic logic [SampleWidth-1:0] random_sample();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 255);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic send_sample(input logic [SampleWidth-1:0] s, input logic known,
                             input logic [SampleWidth-1:0] fixed_avg);
    int                     gap;
    logic [SampleWidth-1:0] predicted;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = next_average(s);
    pending_averages.push_back(known ? fixed_avg : predicted);
  endtask

  task automatic drain_and_write(input logic [CfgWidth-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    window_reg = value;
  endtask

  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(recv_burst);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_averages.size() == 0) begin
        $error("average: unexpected transaction, actual %h", m_axis_tdata);
        fail_count++;
      end else begin
        if (m_axis_tdata !== pending_averages[0]) begin
          $error("average mismatch: expected %h actual %h", pending_averages[0], m_axis_tdata);
          fail_count++;
        end
        void'(pending_averages.pop_front());
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    window_reg    = WindowReset;
    ring_pos      = 0;
    held_count    = 0;
    phase_windows = '{7'd127, 7'd0, 7'd1, 7'd37, 7'd100, 7'd2, 7'd99,
                      CfgWidth'($urandom_range(0, 127)), CfgWidth'($urandom_range(0, 127))};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      send_sample(probes[i].sample, probes[i].known, probes[i].average);
    end

    // first setting keeps the full window so every ring slot gets written
    foreach (phase_windows[p]) begin
      drain_and_write(phase_windows[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        send_sample(random_sample(), 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("windowed_moving_average_unit verification clean");
    end else begin
      $display("windowed_moving_average_unit verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("windowed_moving_average_unit verification failed");
    $finish;
  end

endmodule
